// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define HST_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define HST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define HST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/hst_pkg.sv =====
// ----------------------------------------------------------------------------
// hst_pkg
// Types, constants and helper functions for the hashed score table.
// ----------------------------------------------------------------------------
`default_nettype none

package hst_pkg;

  // Table geometry
  localparam int INDEX_BITS = 16;
  localparam int MOVE_BITS  = 32;
  localparam int SlotCount  = 1 << INDEX_BITS;

  // Configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 15;

  localparam logic [14:0] MATE_THR_RESET   = 15'd30000;
  localparam logic [4:0]  INDEX_BITS_RESET = 5'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MATE_THR   = 1'b0,
    CFG_INDEX_BITS = 1'b1
  } hst_cfg_e;

  // Request function codes
  localparam logic [1:0] FUNC_PROBE = 2'd0;
  localparam logic [1:0] FUNC_STORE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [63:0]        position_key;
    logic [6:0]         ply;
    logic [6:0]         search_depth;
    logic signed [15:0] score_in;
    logic [31:0]        best_move_in;
    logic [1:0]         bound_in;
  } hst_in_t;

  typedef struct packed {
    logic               hit;
    logic [6:0]         depth_out;
    logic signed [15:0] score_out;
    logic [31:0]        best_move_out;
    logic [1:0]         bound_out;
  } hst_out_t;

  // One table slot: key plus payload
  typedef struct packed {
    logic [63:0]           key;
    logic [6:0]            depth;
    logic signed [15:0]    score;
    logic [MOVE_BITS-1:0]  move;
    logic [1:0]            bound;
  } hst_entry_t;

  // Controller state
  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EVAL,
    ST_CLEAR
  } hst_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic take;    // accept request, latch it and read its slot
    logic eval;    // commit: write slot on store, load result register
    logic clr_wr;  // write one empty slot of the sweep
  } hst_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_is_clear;  // offered request is a table clear
    logic out_free;     // result register can take a beat this cycle
    logic clr_last;     // sweep is at the last slot
  } hst_status_t;

  // Slot index from the low key bits; width clamps to 1..INDEX_BITS.
  function automatic logic [INDEX_BITS-1:0] slot_index(logic [63:0] key,
                                                      logic [4:0]  bits_cfg);
    logic [4:0]            b;
    logic [INDEX_BITS-1:0] m;
    b = bits_cfg;
    if (b == 5'd0) b = 5'd1;
    if (int'(b) > INDEX_BITS) b = 5'(INDEX_BITS);
    for (int i = 0; i < INDEX_BITS; i++) begin
      m[i] = (i < int'(b));
    end
    return key[INDEX_BITS-1:0] & m;
  endfunction

  // Mate scores move away from zero by ply (away=1) or back toward it,
  // saturating to 16 bits signed.
  function automatic logic signed [15:0] mate_adjust(logic signed [15:0] score,
                                                     logic [6:0]         ply,
                                                     logic [14:0]        thr,
                                                     logic               away);
    logic signed [17:0] s;
    logic signed [17:0] t;
    logic signed [17:0] p;
    logic signed [17:0] r;
    logic signed [15:0] res;
    s = {{2{score[15]}}, score};
    t = signed'({3'b000, thr});
    p = signed'({11'b0, ply});
    if (s < -t) begin
      r = away ? s - p : s + p;
    end else if (s > t) begin
      r = away ? s + p : s - p;
    end else begin
      r = s;
    end
    if (r > 18'sd32767) begin
      res = 16'sh7fff;
    end else if (r < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = r[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/hst_datapath.sv =====
// ----------------------------------------------------------------------------
// hst_datapath
// Slot memory, request registers, read-modify-write logic, clear sweep
// counter, configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hst_datapath import hst_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire hst_in_t             in_i,
  output hst_out_t                 out_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire hst_cmd_t            cmd_i,
  output hst_status_t              status_o
);

  // Slot memory, no reset: emptied by the clear sweep
  hst_entry_t mem [SlotCount];

  logic [14:0]           mate_thr_q;
  logic [4:0]            idx_bits_q;
  hst_in_t               req_q;
  logic [INDEX_BITS-1:0] idx_q;
  hst_entry_t            rd_q;
  logic [INDEX_BITS-1:0] clr_cnt_q;
  logic                  out_valid_q;
  hst_out_t              out_q;

  logic [INDEX_BITS-1:0] rd_idx;
  logic                  is_probe;
  logic                  is_store;
  logic                  slot_occ;
  logic                  key_eq;
  logic                  keep;
  logic                  hit;
  logic signed [15:0]    adj_src;
  logic signed [15:0]    adj_score;
  hst_entry_t            new_entry;
  logic                  mem_we;
  logic [INDEX_BITS-1:0] wr_addr;
  hst_entry_t            wr_data;
  hst_out_t              result;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mate_thr_q <= MATE_THR_RESET;
      idx_bits_q <= INDEX_BITS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MATE_THR:   mate_thr_q <= cfg_data_i[14:0];
        CFG_INDEX_BITS: idx_bits_q <= cfg_data_i[4:0];
        default:        ;
      endcase
    end
  end

  assign rd_idx = slot_index(in_i.position_key, idx_bits_q);

  // Request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_q <= in_i;
      idx_q <= rd_idx;
    end
  end

  // Registered memory read at accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rd_q <= mem[rd_idx];
    end
  end

  // Evaluate the slot against the request
  assign is_probe = (req_q.func == FUNC_PROBE);
  assign is_store = (req_q.func == FUNC_STORE);
  assign slot_occ = (rd_q.bound != 2'd0);
  assign key_eq   = (rd_q.key == req_q.position_key);
  assign keep     = slot_occ && key_eq && (rd_q.depth > req_q.search_depth);
  assign hit      = is_probe && slot_occ && key_eq;

  // One adjuster: probe pulls the stored score back, store pushes away
  assign adj_src   = is_probe ? rd_q.score : req_q.score_in;
  assign adj_score = mate_adjust(adj_src, req_q.ply, mate_thr_q, is_store);

  always_comb begin
    new_entry.key   = req_q.position_key;
    new_entry.depth = req_q.search_depth;
    new_entry.score = adj_score;
    new_entry.move  = req_q.best_move_in[MOVE_BITS-1:0];
    new_entry.bound = req_q.bound_in;
  end

  // Write port shared by the sweep and the store commit
  assign mem_we  = cmd_i.clr_wr || (cmd_i.eval && is_store && !keep);
  assign wr_addr = cmd_i.clr_wr ? clr_cnt_q : idx_q;
  assign wr_data = cmd_i.clr_wr ? '0 : new_entry;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Sweep counter wraps back to zero after the last slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Result: stored entry, with its score adjusted by ply, on a probe hit, else all zero
  always_comb begin
    result = '0;
    if (hit) begin
      result.hit           = 1'b1;
      result.depth_out     = rd_q.depth;
      result.score_out     = adj_score;
      result.best_move_out = 32'(rd_q.move);
      result.bound_out     = rd_q.bound;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.eval) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      out_q <= result;
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  assign status_o.in_is_clear = (in_i.func == FUNC_CLEAR);
  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign status_o.clr_last    = &clr_cnt_q;

endmodule

`default_nettype wire

// ===== design/hst_ctrl.sv =====
// ----------------------------------------------------------------------------
// hst_ctrl
// Sequencer: reset sweep, request accept, evaluate/commit, table clear.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hst_ctrl import hst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire hst_status_t status_i,
  output hst_cmd_t         cmd_o
);

  hst_state_e state_q;
  hst_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = status_i.in_is_clear ? ST_CLEAR : ST_EVAL;
      end
      ST_EVAL: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_EVAL;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT:  cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_EVAL:  cmd_o.eval = status_i.out_free;
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      default:  ;
    endcase
  end

  // A commit never meets a stalled result register
  `HST_ASSERT_IMPL(a_eval_free, clk_i, rst_ni, cmd_o.eval, status_i.out_free)
  // Commit finishes the request
  `HST_ASSERT_NEXT(a_eval_done, clk_i, rst_ni, cmd_o.eval, state_q == ST_IDLE)
  // Sweep and commit never share the write port
  `HST_ASSERT(a_wr_excl, clk_i, rst_ni, !(cmd_o.clr_wr && cmd_o.eval))
  // End of a clear sweep leads to its result beat
  `HST_ASSERT_NEXT(a_clear_res, clk_i, rst_ni,
                   (state_q == ST_CLEAR) && status_i.clr_last, state_q == ST_EVAL)

endmodule

`default_nettype wire

// ===== design/hashed_score_table_top.sv =====
// ----------------------------------------------------------------------------
// hashed_score_table_top
// Direct-mapped, depth-preferred transposition table with probe, store and
// clear requests and ply-based mate score adjustment.
// ----------------------------------------------------------------------------
// Each request yields one result beat. A probe or store is accepted and its
// slot read from the table memory; then the slot is compared, written back
// on a store and the result register loaded. A stalled result register
// holds this second step until it frees up. A clear request sweeps all
// 2^INDEX_BITS slots of the memory one slot per cycle, then returns its
// result beat. After reset the same sweep runs over every slot with
// in_ready_o low; configuration writes are taken during it.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_score_table_top import hst_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire hst_in_t             in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output hst_out_t                 out_o
);

  hst_cmd_t    cmd;
  hst_status_t status;

  hst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hst_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire
